FILE: hw/rtl/lsmc_pkg.sv
// lsmc_pkg: shared constants, types and helpers of the led segment mode controller
// depends on nothing; used by the register block and the top level

package lsmc_pkg;

	localparam int unsigned REG_W      = 23;
	localparam int unsigned PHASE_W    = 24;
	localparam int unsigned IDX_W      = 7;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned EN_W       = 2;
	localparam int unsigned LED_W      = 3;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [REG_W-1:0] DWELL_RESET = REG_W'(50000);
	localparam logic [REG_W-1:0] BUZZ_RESET  = REG_W'(50000);
	localparam logic [IDX_W:0]   COUNT_MOD   = (IDX_W+1)'(100);

	// register indexes, taken from paddr[2]
	localparam logic REG_DWELL = 1'b0;
	localparam logic REG_BUZZ  = 1'b1;

	// run mode codes
	localparam logic [MODE_W-1:0] MODE_SEGMENT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRAIN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COUNTER = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

	// digit enable codes
	localparam logic [EN_W-1:0] EN_NONE = 2'd0;
	localparam logic [EN_W-1:0] EN_ONES = 2'd1;
	localparam logic [EN_W-1:0] EN_TENS = 2'd2;

	typedef struct packed {
		logic [REG_W-1:0] dwell_ticks;
		logic [REG_W-1:0] buzz_ticks;
	} cfg_t;

	// tens digit by reciprocal multiply, exact for every 7-bit value
	function automatic logic [DIGIT_W-1:0] tens_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W+8-1:0] prod;
		prod = {8'd0, idx} * (IDX_W+8)'(205);
		return DIGIT_W'(prod >> 11);
	endfunction

	function automatic logic [DIGIT_W-1:0] ones_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] t10;
		t10 = IDX_W'({3'd0, tens_of(idx)} * 7'd10);
		return DIGIT_W'(idx - t10);
	endfunction

	function automatic logic [LED_W-1:0] led_bit(input logic [IDX_W-1:0] pos);
		logic [LED_W-1:0] b;
		b = '0;
		if (pos < IDX_W'(LED_W)) begin
			b[pos[1:0]] = 1'b1;
		end
		return b;
	endfunction

endpackage

FILE: hw/rtl/lsmc_in_if.sv
// lsmc_in_if: button tick channel, valid/ready handshake with the three press flags
// depends on nothing

interface lsmc_in_if;
	logic valid;
	logic ready;
	logic mode_press;
	logic step_press;
	logic buzz_press;

	modport source (output valid, mode_press, step_press, buzz_press, input ready);
	modport sink   (input valid, mode_press, step_press, buzz_press, output ready);
endinterface

FILE: hw/rtl/lsmc_out_if.sv
// lsmc_out_if: display result channel, valid/ready handshake with the output fields
// depends on nothing

interface lsmc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_value;
	logic [1:0] digit_enables;
	logic [2:0] led_bits;
	logic       buzzer_on;
	logic [1:0] current_mode;

	modport source (output valid, digit_value, digit_enables, led_bits, buzzer_on,
		current_mode, input ready);
	modport sink   (input valid, digit_value, digit_enables, led_bits, buzzer_on,
		current_mode, output ready);
endinterface

FILE: hw/rtl/lsmc_cfg_regs.sv
// lsmc_cfg_regs: apb register block holding dwell_ticks and buzz_ticks
// depends on lsmc_pkg

module lsmc_cfg_regs import lsmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dwell_ticks <= DWELL_RESET;
			cfg_q.buzz_ticks  <= BUZZ_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DWELL: cfg_q.dwell_ticks <= pwdata[REG_W-1:0];
				REG_BUZZ:  cfg_q.buzz_ticks  <= pwdata[REG_W-1:0];
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DWELL: prdata = APB_DATA_W'(cfg_q.dwell_ticks);
			REG_BUZZ:  prdata = APB_DATA_W'(cfg_q.buzz_ticks);
			default:   prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/led_segment_mode_controller.sv
// led_segment_mode_controller: top level of the led / seven-segment mode controller
// depends on lsmc_pkg, lsmc_in_if, lsmc_out_if and lsmc_cfg_regs

// One tick transfer in gives one result transfer out. A tick is captured in an
// input register, its whole update (buzzer hold, mode press, then segment, train
// or counter action) is short logic, and the result lands in an output register;
// a tick is taken in every cycle as long as the result side keeps taking
// results. A stalled result holds the output register and the input register;
// the state advances only when a tick moves into the output register.
// dwell_ticks (byte 0) and buzz_ticks (byte 4) are written over apb; the user
// must write them only while the block is idle, and the block itself does not
// enforce it. Both reset to 50000.

module led_segment_mode_controller import lsmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	lsmc_in_if.sink               item,
	lsmc_out_if.source            result
);

	cfg_t cfg;

	lsmc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic valid_s1, mode_p_s1, step_p_s1, buzz_p_s1;
	// output register
	logic out_valid_q;
	logic advance;

	// controller state
	logic [MODE_W-1:0]  mode_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PHASE_W-1:0] phase_q;
	logic               sweep_q;
	logic [REG_W-1:0]   buzz_cnt_q;
	logic               buzz_out_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [EN_W-1:0]    en_q;
	logic [LED_W-1:0]   led_q;

	logic [MODE_W-1:0]  mode_d;
	logic [IDX_W-1:0]   idx_d;
	logic [PHASE_W-1:0] phase_d;
	logic               sweep_d;
	logic [REG_W-1:0]   buzz_cnt_d;
	logic               buzz_out_d;
	logic [DIGIT_W-1:0] digit_d;
	logic [EN_W-1:0]    en_d;
	logic [LED_W-1:0]   led_d;

	// the s1 tick moves on when the output register is empty or being drained
	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready & item.valid) begin
			mode_p_s1 <= item.mode_press;
			step_p_s1 <= item.step_press;
			buzz_p_s1 <= item.buzz_press;
		end
	end

	// one tick of the controller
	always_comb begin
		logic [PHASE_W-1:0] dwell;
		logic [PHASE_W-1:0] phase_inc;
		logic [IDX_W:0]     idx_next;
		logic [LED_W-1:0]   cur_bit;

		// buzzer hold, counts down and stops at zero
		buzz_cnt_d = buzz_cnt_q;
		buzz_out_d = buzz_out_q;
		if (buzz_p_s1) begin
			buzz_cnt_d = cfg.buzz_ticks;
			buzz_out_d = 1'b1;
		end else begin
			if (buzz_cnt_q != '0) begin
				buzz_cnt_d = buzz_cnt_q - 1'b1;
			end
			if (buzz_cnt_d == '0) begin
				buzz_out_d = 1'b0;
			end
		end

		mode_d  = mode_q;
		idx_d   = idx_q;
		phase_d = phase_q;
		sweep_d = sweep_q;
		digit_d = digit_q;
		en_d    = en_q;
		led_d   = led_q;

		// mode press clears the display state; the digit value stays
		if (mode_p_s1) begin
			idx_d   = '0;
			en_d    = EN_NONE;
			led_d   = '0;
			phase_d = '0;
			sweep_d = 1'b0;
			case (mode_q)
				MODE_SEGMENT: mode_d = MODE_TRAIN;
				MODE_TRAIN:   mode_d = MODE_COUNTER;
				default:      mode_d = MODE_SEGMENT;
			endcase
		end

		dwell     = PHASE_W'(cfg.dwell_ticks);
		phase_inc = phase_d + 1'b1;
		idx_next  = '0;
		cur_bit   = led_bit(idx_d);

		case (mode_d)
			MODE_SEGMENT: begin
				if (phase_d == '0) begin
					en_d    = EN_ONES;
					digit_d = ones_of(idx_d);
					phase_d = phase_inc;
				end else if (phase_d < dwell) begin
					phase_d = phase_inc;
				end else if (phase_d == dwell) begin
					en_d    = EN_TENS;
					digit_d = tens_of(idx_d);
					phase_d = phase_inc;
				end else if (phase_d < {dwell[PHASE_W-2:0], 1'b0}) begin
					phase_d = phase_inc;
				end else begin
					// count wraps at 100
					idx_next = {1'b0, idx_d} + 1'b1;
					if (idx_next >= COUNT_MOD) begin
						idx_next = idx_next - COUNT_MOD;
					end
					idx_d   = idx_next[IDX_W-1:0];
					phase_d = '0;
				end
			end
			MODE_TRAIN: begin
				if (phase_d == '0) begin
					led_d   = led_d | cur_bit;
					phase_d = phase_inc;
				end else if (phase_d < dwell) begin
					phase_d = phase_inc;
				end else begin
					led_d   = led_d & ~cur_bit;
					idx_d   = sweep_d ? idx_d - 1'b1 : idx_d + 1'b1;
					if (idx_d == IDX_W'(2)) begin
						sweep_d = 1'b1;
					end else if (idx_d == '0) begin
						sweep_d = 1'b0;
					end
					phase_d = '0;
				end
			end
			MODE_COUNTER: begin
				if (step_p_s1) begin
					idx_d = sweep_d ? idx_d - 1'b1 : idx_d + 1'b1;
					if (idx_d == IDX_W'(7)) begin
						sweep_d = 1'b1;
					end else if (idx_d == '0) begin
						sweep_d = 1'b0;
					end
					led_d = idx_d[LED_W-1:0];
				end
			end
			default: begin
				// unused mode code: no action
			end
		endcase
	end

	// state and result update on each tick that moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SEGMENT;
			idx_q      <= '0;
			phase_q    <= '0;
			sweep_q    <= 1'b0;
			buzz_cnt_q <= '0;
			buzz_out_q <= 1'b0;
			digit_q    <= '0;
			en_q       <= EN_NONE;
			led_q      <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			idx_q      <= idx_d;
			phase_q    <= phase_d;
			sweep_q    <= sweep_d;
			buzz_cnt_q <= buzz_cnt_d;
			buzz_out_q <= buzz_out_d;
			digit_q    <= digit_d;
			en_q       <= en_d;
			led_q      <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the state registers double as the result register
	assign result.valid         = out_valid_q;
	assign result.digit_value   = digit_q;
	assign result.digit_enables = en_q;
	assign result.led_bits      = led_q;
	assign result.buzzer_on     = buzz_out_q;
	assign result.current_mode  = mode_q;

	// checks

	// a running hold count always means the buzzer is driven
	a_buzz_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(buzz_cnt_q != '0) |-> buzz_out_q)
		else $error("buzzer off while hold count runs");

	// at most one digit enabled at a time
	a_digit_en: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(en_q))
		else $error("both digits enabled");

	// train mode lights at most one led
	a_train_led: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_TRAIN) |-> $onehot0(led_q))
		else $error("more than one led lit in train mode");

	// a tick that moves on always shows up as a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("tick moved on without a result");

endmodule
